[sv/ipv4c_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 dotted-string checker package
// Shared constants, the error code set and the running scan state record.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4c_pkg;

  localparam int unsigned CharWidth = 8;

  localparam logic [4:0] LEN_MIN    = 5'd7;
  localparam logic [4:0] LEN_MAX    = 5'd15;
  localparam logic [4:0] COUNT_SAT  = 5'd16;
  localparam logic [8:0] OCTET_MAX  = 9'd255;
  localparam logic [8:0] OCTET_SAT  = 9'd256;
  localparam logic [2:0] DIGITS_MAX = 3'd3;
  localparam logic [2:0] DIGITS_SAT = 3'd4;
  localparam logic [1:0] DOTS_NEED  = 2'd3;
  localparam logic [1:0] PREFIX_LEN = 2'd3;

  localparam logic [CharWidth-1:0] CH_ZERO = 8'h30;
  localparam logic [CharWidth-1:0] CH_NINE = 8'h39;
  localparam logic [CharWidth-1:0] CH_DOT  = 8'h2E;
  localparam logic [CharWidth-1:0] CH_TWO  = 8'h32;
  localparam logic [CharWidth-1:0] CH_FIVE = 8'h35;

  typedef enum logic [3:0] {
    ERR_OK         = 4'd0,
    ERR_LEN        = 4'd1,
    ERR_START      = 4'd2,
    ERR_DOT_EDGE   = 4'd3,
    ERR_CHAR       = 4'd4,
    ERR_EXTRA_DOT  = 4'd5,
    ERR_LONG_OCTET = 4'd6,
    ERR_VALUE      = 4'd7,
    ERR_FEW_DOTS   = 4'd8
  } err_t;

  // Running state of one string, cleared after its final character.
  typedef struct packed {
    logic [4:0] char_count;
    logic [1:0] dot_count;
    logic [8:0] octet_value;
    logic [2:0] octet_digits;
    logic [1:0] prefix_track;
    logic       start_zero;
    logic       start_dot;
    logic       prev_was_dot;
    err_t       loop_error;
  } scan_state_t;

  // Characters of the forbidden leading "255".
  function automatic logic [CharWidth-1:0] prefix_char(input logic [1:0] idx);
    logic [CharWidth-1:0] c;
    case (idx)
      2'd0:    c = CH_TWO;
      default: c = CH_FIVE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/ipv4c_char_if.sv]
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one character and its end-of-string mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4c_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink   (input valid, input ch, input last_char, output ready);
endinterface

`default_nettype wire

[sv/ipv4c_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the verdict for one string.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4c_res_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [3:0] error_code;

  modport source (output valid, output valid_res, output error_code, input ready);
  modport sink   (input valid, input valid_res, input error_code, output ready);
endinterface

`default_nettype wire

[sv/ipv4c_scan.sv]
// ----------------------------------------------------------------------------
// IPv4 checker scan stage
// Holds the running string state and works out its update for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4c_scan (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic [7:0]            ch,
  input  wire logic                  last_char,
  output ipv4c_pkg::scan_state_t     state_next
);
  import ipv4c_pkg::*;

  scan_state_t state;
  logic        is_digit;
  logic        is_dot;
  logic [11:0] scaled;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_dot   = (ch == CH_DOT);
  assign scaled   = 12'(state.octet_value) * 12'd10 + 12'(ch[3:0]);

  always_comb begin
    state_next = state;

    if (state.char_count == 5'd0) begin
      if (ch == CH_ZERO) state_next.start_zero = 1'b1;
      if (is_dot)        state_next.start_dot  = 1'b1;
    end
    if ((state.char_count < 5'(PREFIX_LEN)) &&
        (5'(state.prefix_track) == state.char_count) &&
        (ch == prefix_char(state.char_count[1:0]))) begin
      state_next.prefix_track = state.prefix_track + 2'd1;
    end

    if (is_digit) begin
      state_next.octet_value = (scaled > 12'(OCTET_SAT)) ? OCTET_SAT : scaled[8:0];
      if (state.octet_digits < DIGITS_SAT)
        state_next.octet_digits = state.octet_digits + 3'd1;
    end else if (is_dot) begin
      if (state.dot_count == DOTS_NEED) begin
        if (state.loop_error == ERR_OK) state_next.loop_error = ERR_EXTRA_DOT;
      end else begin
        state_next.dot_count = state.dot_count + 2'd1;
        if (state.octet_digits > DIGITS_MAX) begin
          if (state.loop_error == ERR_OK) state_next.loop_error = ERR_LONG_OCTET;
        end else if (state.octet_value > OCTET_MAX) begin
          if (state.loop_error == ERR_OK) state_next.loop_error = ERR_VALUE;
        end else begin
          state_next.octet_value  = '0;
          state_next.octet_digits = '0;
        end
      end
    end else begin
      if (state.loop_error == ERR_OK) state_next.loop_error = ERR_CHAR;
    end

    state_next.prev_was_dot = is_dot;
    if (state.char_count < COUNT_SAT)
      state_next.char_count = state.char_count + 5'd1;
  end

  // Advance on every taken character; start fresh after the final one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= last_char ? scan_state_t'('0) : state_next;
    end
  end

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    state.char_count <= COUNT_SAT)
    else $error("character count past saturation");
  a_value_sat: assert property (@(posedge clk) disable iff (rst)
    state.octet_value <= OCTET_SAT)
    else $error("octet value past saturation");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && last_char) |=> (state.char_count == 5'd0 && state.loop_error == ERR_OK))
    else $error("state not cleared after final character");

endmodule

`default_nettype wire

[sv/ipv4c_judge.sv]
// ----------------------------------------------------------------------------
// IPv4 checker verdict logic
// Ranks the end-of-string checks and picks the reported error code.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4c_judge (
  input  wire ipv4c_pkg::scan_state_t state,
  output ipv4c_pkg::err_t             code
);
  import ipv4c_pkg::*;

  always_comb begin
    if ((state.char_count < LEN_MIN) || (state.char_count > LEN_MAX))
      code = ERR_LEN;
    else if (state.start_zero || (state.prefix_track == PREFIX_LEN))
      code = ERR_START;
    else if (state.start_dot || state.prev_was_dot)
      code = ERR_DOT_EDGE;
    else if (state.loop_error != ERR_OK)
      code = state.loop_error;
    else if (state.dot_count != DOTS_NEED)
      code = ERR_FEW_DOTS;
    else if (state.octet_value > OCTET_MAX)
      code = ERR_VALUE;
    else
      code = ERR_OK;
  end

endmodule

`default_nettype wire

[sv/ipv4_dotted_string_checker.sv]
// ----------------------------------------------------------------------------
// IPv4 dotted-string checker
// Checks a dotted-decimal IPv4 text streamed one character per request.
// ----------------------------------------------------------------------------
// Feed the address text one character per request on chars, with last_char
// set on the final character; every string must have at least one character.
// One request is taken per clock cycle, back to back unless stalled. Each
// character updates a small set of running counters, and the verdict for the
// string lands in the result register on the cycle after its final character
// is taken, appearing on results as valid_res (1 = good address) and error_code
// (0 ok, 1 length, 2 leading '0' or "255", 3 dot at start or end, 4 bad
// character, 5 extra dot, 6 octet over three digits, 7 octet above 255, 8 too
// few dots). Checks are ranked in that order (a final octet's 7 after 8); among
// the scan faults (4 to 7 before the last dot) the first one seen wins. The
// result register is the only buffer: chars.ready drops only while a verdict
// is waiting and results.ready is low, and characters that are not final keep
// flowing as long as the result register can still take a new verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_string_checker (
  input wire logic clk,
  input wire logic rst,
  ipv4c_char_if.sink   chars,
  ipv4c_res_if.source  results
);
  import ipv4c_pkg::*;

  scan_state_t state_next;
  err_t        code;
  logic        take;
  logic        res_valid;
  logic        valid_res;
  err_t        error_code;

  // Accept while the result register is empty or being drained this cycle.
  assign chars.ready = !res_valid || results.ready;
  assign take        = chars.valid && chars.ready;

  ipv4c_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .ch         (chars.ch),
    .last_char  (chars.last_char),
    .state_next (state_next)
  );

  ipv4c_judge u_judge (
    .state (state_next),
    .code  (code)
  );

  // Result valid: set by a final character, drop once taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && chars.last_char) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload: load with the verdict of the string just finished.
  always_ff @(posedge clk) begin
    if (take && chars.last_char) begin
      valid_res  <= (code == ERR_OK);
      error_code <= code;
    end
  end

  assign results.valid      = res_valid;
  assign results.valid_res  = valid_res;
  assign results.error_code = error_code;

  a_verdict_follows_last: assert property (@(posedge clk) disable iff (rst)
    (take && chars.last_char) |=> res_valid)
    else $error("no verdict after final character");
  a_no_spurious_verdict: assert property (@(posedge clk) disable iff (rst)
    (!res_valid && !(take && chars.last_char)) |=> !res_valid)
    else $error("verdict without a final character");
  a_flag_matches_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (valid_res == (error_code == ERR_OK)))
    else $error("valid flag disagrees with error code");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !results.ready) |-> !take)
    else $error("character taken while verdict stalled");

endmodule

`default_nettype wire

[verif/ipv4c_verdict_checker.sv]
// ----------------------------------------------------------------------------
// IPv4 dotted-string verdict checker
// Watches the character and result channels, rebuilds the verdict of every
// string from the accepted characters and compares it with the block's result.
// ----------------------------------------------------------------------------
module ipv4c_verdict_checker (
  input  logic        clk,
  input  logic        rst,
  ipv4c_char_if       chars,
  ipv4c_res_if        results,
  output int          fail_count,
  output int          pending
);
  import ipv4c_pkg::*;

  typedef struct {
    logic [4:0] n_chars;
    logic [1:0] n_dots;
    logic [8:0] octet_val;
    logic [2:0] octet_len;
    logic [1:0] match_255;
    logic       lead_zero;
    logic       lead_dot;
    logic       ends_dot;
    err_t       first_fault;
  } scan_t;

  typedef struct packed {
    logic ok;
    err_t code;
  } verdict_t;

  scan_t    scan;
  verdict_t verdict_q[$];

  function automatic scan_t fresh_scan();
    scan_t s;
    s.n_chars     = '0;
    s.n_dots      = '0;
    s.octet_val   = '0;
    s.octet_len   = '0;
    s.match_255   = '0;
    s.lead_zero   = 1'b0;
    s.lead_dot    = 1'b0;
    s.ends_dot    = 1'b0;
    s.first_fault = ERR_OK;
    return s;
  endfunction

  // Keep only the first scan fault of a string.
  function automatic void note_fault(inout scan_t s, input err_t code);
    if (s.first_fault == ERR_OK) s.first_fault = code;
  endfunction

  function automatic void absorb_char(inout scan_t s, input logic [7:0] c);
    logic        digit;
    logic        dot;
    logic [12:0] acc;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dot   = (c == CH_DOT);
    if (s.n_chars == 0) begin
      if (c == CH_ZERO) s.lead_zero = 1'b1;
      if (dot) s.lead_dot = 1'b1;
    end
    if (s.n_chars < 3 && s.match_255 == s.n_chars[1:0] &&
        c == ((s.n_chars == 0) ? CH_TWO : CH_FIVE))
      s.match_255 = s.match_255 + 2'd1;
    if (digit) begin
      acc = s.octet_val * 13'd10 + 13'(c - CH_ZERO);
      s.octet_val = (acc > 13'(OCTET_SAT)) ? OCTET_SAT : acc[8:0];
      if (s.octet_len < DIGITS_SAT) s.octet_len = s.octet_len + 3'd1;
    end else if (dot) begin
      if (s.n_dots >= DOTS_NEED) begin
        note_fault(s, ERR_EXTRA_DOT);
      end else begin
        s.n_dots = s.n_dots + 2'd1;
        if (s.octet_len > DIGITS_MAX) begin
          note_fault(s, ERR_LONG_OCTET);
        end else if (s.octet_val > OCTET_MAX) begin
          note_fault(s, ERR_VALUE);
        end else begin
          s.octet_val = '0;
          s.octet_len = '0;
        end
      end
    end else begin
      note_fault(s, ERR_CHAR);
    end
    s.ends_dot = dot;
    if (s.n_chars < COUNT_SAT) s.n_chars = s.n_chars + 5'd1;
  endfunction

  function automatic err_t string_verdict(input scan_t s);
    if (s.n_chars < LEN_MIN || s.n_chars > LEN_MAX) return ERR_LEN;
    if (s.lead_zero || s.match_255 == PREFIX_LEN) return ERR_START;
    if (s.lead_dot || s.ends_dot) return ERR_DOT_EDGE;
    if (s.first_fault != ERR_OK) return s.first_fault;
    if (s.n_dots != DOTS_NEED) return ERR_FEW_DOTS;
    if (s.octet_val > OCTET_MAX) return ERR_VALUE;
    return ERR_OK;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    err_t     code;
    if (rst) begin
      scan = fresh_scan();
      verdict_q.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result with no string pending: valid_res=%0b error_code=%0d",
                 results.valid_res, results.error_code);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (results.valid_res !== want.ok) begin
            $error("valid_res: expected %0b, actual %0b", want.ok, results.valid_res);
            fail_count++;
          end
          if (results.error_code !== want.code) begin
            $error("error_code: expected %0d, actual %0d", want.code, results.error_code);
            fail_count++;
          end
        end
      end
      if (chars.valid && chars.ready) begin
        absorb_char(scan, chars.ch);
        if (chars.last_char) begin
          code      = string_verdict(scan);
          want.ok   = (code == ERR_OK);
          want.code = code;
          verdict_q.insert(verdict_q.size(), want);
          scan = fresh_scan();
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

[verif/ipv4_dotted_string_checker_tb.sv]
// ----------------------------------------------------------------------------
// IPv4 dotted-string checker testbench
// Streams directed and random address texts through the block and lets the
// verdict checker compare every result, under three idling patterns.
// ----------------------------------------------------------------------------
module ipv4_dotted_string_checker_tb;
  import ipv4c_pkg::*;

  typedef logic [7:0] char_q_t[$];

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   n_sent = 0;

  // Percent of cycles in which each side holds off; changed between phases.
  int   tx_idle_pct = 17;
  int   rx_idle_pct = 60;

  ipv4c_char_if chars_if ();
  ipv4c_res_if  res_if ();

  ipv4_dotted_string_checker DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (res_if)
  );

  ipv4c_verdict_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .results    (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: stall at random at the current rate; zero means always ready.
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic char_q_t to_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    return q;
  endfunction

  // Octet text biased toward the interesting values: small, near 255, above
  // 255 and far above it, now and then with a padding zero in front.
  function automatic string octet_text();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom_range(255);
      5:             v = $urandom_range(9);
      6:             v = $urandom_range(255, 250);
      7:             v = $urandom_range(259, 200);
      8:             v = $urandom_range(9999, 256);
      default:       v = 0;
    endcase
    if ($urandom_range(7) == 0) return $sformatf("0%0d", v);
    return $sformatf("%0d", v);
  endfunction

  // Mostly well-formed addresses, a quarter of them damaged in one spot; the
  // rest is digit/dot soup or raw bytes.
  function automatic char_q_t make_string();
    char_q_t q;
    int      kind;
    int      pos;
    int      n;
    kind = $urandom_range(99);
    if (kind < 70) begin
      q = to_chars({octet_text(), ".", octet_text(), ".", octet_text(), ".", octet_text()});
      if ($urandom_range(3) == 0) begin
        pos = $urandom_range(q.size() - 1);
        case ($urandom_range(3))
          0:       q[pos] = 8'($urandom_range(255));
          1:       q.insert(pos, CH_DOT);
          2:       if (q.size() > 1) q.delete(pos);
          default: q.insert(q.size(), 8'(CH_ZERO + $urandom_range(9)));
        endcase
      end
    end else if (kind < 85) begin
      n = $urandom_range(18, 1);
      repeat (n) begin
        if ($urandom_range(10) == 10) q.insert(q.size(), CH_DOT);
        else q.insert(q.size(), 8'(CH_ZERO + $urandom_range(9)));
      end
    end else begin
      n = $urandom_range(20, 1);
      repeat (n) q.insert(q.size(), 8'($urandom_range(255)));
    end
    return q;
  endfunction

  // Present one character and hold it until the block takes the request.
  task automatic send_one(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.ch        <= c;
    chars_if.last_char <= fin;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_chars(input char_q_t q);
    foreach (q[i]) send_one(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    send_chars(to_chars(s));
  endtask

  initial begin
    char_q_t q;
    int      guard;

    rst                <= 1'b1;
    chars_if.valid     <= 1'b0;
    chars_if.ch        <= '0;
    chars_if.last_char <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: good addresses at both length limits, partial "255"
    // prefix, empty octet, four-digit final octet that only gets the value
    // check, then strings for every error code.
    send_text("1.2.3.4");
    send_text("192.168.100.200");
    send_text("25.1.2.3");
    send_text("1..2.3.4");
    send_text("1.2.3.0255");
    send_text("1");
    send_text("1.2.3");
    send_text("1234567890.1234567890");
    send_text("0.1.2.3");
    send_text("255.1.2.3");
    send_text(".1.2.3.4");
    send_text("1.2.3.4.");
    send_text("1.2.a.4");
    send_text("9/9.1.2.3");
    send_text("1.2.3:4");
    // Character code extremes inside otherwise good text.
    q = to_chars("1.2.3.4");
    q[2] = 8'h00;
    send_chars(q);
    q[2] = CH_TWO;
    q[0] = 8'hFF;
    send_chars(q);
    send_text("1.2.3.4.5");
    send_text("1234.1.2.3");
    send_text("256.1.2.3");
    send_text("1.2.3.256");
    send_text("1.2.3.99999");
    send_text("1.2.3456");
    // First fault wins over later ones; saturated value beats the extra dot.
    send_text("1.2a3.999.4");
    send_text("999.2.3.4.5");

    // Random phases: slow sender and slow receiver swap, then full rate.
    while (n_sent < 317) send_chars(make_string());
    tx_idle_pct = 60;
    rx_idle_pct <= 17;
    while (n_sent < 633) send_chars(make_string());
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    while (n_sent < 950) send_chars(make_string());
    chars_if.valid <= 1'b0;

    // Drain outstanding verdicts, then give the result register time to
    // show anything unexpected.
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ipv4c_pkg.sv
sv/ipv4c_char_if.sv
sv/ipv4c_res_if.sv
sv/ipv4c_scan.sv
sv/ipv4c_judge.sv
sv/ipv4_dotted_string_checker.sv
verif/ipv4c_verdict_checker.sv
verif/ipv4_dotted_string_checker_tb.sv
